>>> src/pcl_pkg.sv
// Shared types and constants for the particle cell locator.
// Used by the top level, the axis divider and the port checker.
package pcl_pkg;

  localparam int NUM_AXES        = 3;
  localparam int CFG_IDX_BITS    = 3;
  localparam int CFG_DATA_BITS   = 32;
  localparam int SIZE_BITS       = 31;
  localparam int COUNTS_REG_BITS = 30;
  localparam int IDX_BITS        = 30;

  localparam logic [SIZE_BITS-1:0]       SIZE_RESET   = 31'd65536;
  localparam logic [COUNTS_REG_BITS-1:0] COUNTS_RESET = 30'd1049601;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_ORIGIN_X    = 3'd0,
    REG_ORIGIN_Y    = 3'd1,
    REG_ORIGIN_Z    = 3'd2,
    REG_CELL_SIZE_X = 3'd3,
    REG_CELL_SIZE_Y = 3'd4,
    REG_CELL_SIZE_Z = 3'd5,
    REG_CELL_COUNTS = 3'd6
  } cfg_reg_t;

endpackage

>>> src/pcl_axis_div.sv
// Pipelined restoring divider for one axis: one quotient bit per stage.
// Depends on pcl_pkg for the cell size width.
module pcl_axis_div import pcl_pkg::*; #(
  parameter int QB = 10
) (
  input  logic                    clk,
  input  logic [QB-1:0]           en,
  input  logic [SIZE_BITS+QB-1:0] rem_in,
  input  logic                    bad_in,
  input  logic [SIZE_BITS-1:0]    size,
  output logic [QB-1:0]           quo,
  output logic                    bad
);

  localparam int DW = SIZE_BITS + QB;

  logic [DW-1:0] rem_r [QB];
  logic [QB-1:0] quo_r [QB];
  logic [QB-1:0] bad_r;

  logic [DW-1:0] rem_c [QB];
  logic [QB-1:0] quo_c [QB];
  logic [QB-1:0] bad_c;
  logic [DW-1:0] dvs   [QB];
  logic [QB-1:0] ge;

  always_comb begin
    rem_c[0] = rem_in;
    quo_c[0] = '0;
    bad_c[0] = bad_in;
    for (int k = 1; k < QB; k++) begin
      rem_c[k] = rem_r[k-1];
      quo_c[k] = quo_r[k-1];
      bad_c[k] = bad_r[k-1];
    end
    for (int k = 0; k < QB; k++) begin
      dvs[k] = DW'(size) << (QB - 1 - k);
      ge[k]  = rem_c[k] >= dvs[k];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < QB; k++) begin
      if (en[k]) begin
        rem_r[k] <= ge[k] ? rem_c[k] - dvs[k] : rem_c[k];
        quo_r[k] <= quo_c[k] | (ge[k] ? (QB'(1) << (QB - 1 - k)) : '0);
        bad_r[k] <= bad_c[k];
      end
    end
  end

  assign quo = quo_r[QB-1];
  assign bad = bad_r[QB-1];

endmodule

>>> src/particle_cell_locator_top.sv
// Particle cell locator: position in, flat cell index of a uniform 3D grid out.
// Depends on pcl_pkg and pcl_axis_div.
// Throughput one item per cycle while the output is not stalled by out_ready.
// The divider takes one stage per quotient bit, which sets the depth.
// Synchronous reset empties the pipeline and loads the register defaults.
// The configuration port is always ready.
module particle_cell_locator_top import pcl_pkg::*; #(
  parameter int COUNT_BITS = 10,
  parameter int COORD_BITS = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [COORD_BITS-1:0]    pos_x,
  input  logic [COORD_BITS-1:0]    pos_y,
  input  logic [COORD_BITS-1:0]    pos_z,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [IDX_BITS-1:0]      cell_index,
  output logic                     out_of_range,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  localparam int DW   = SIZE_BITS + COUNT_BITS;
  localparam int OW   = COORD_BITS + 1;
  localparam int CMPW = (COORD_BITS > DW) ? COORD_BITS : DW;
  localparam int NS   = COUNT_BITS + 4;
  localparam int ST_C = COUNT_BITS + 2;
  localparam int ST_E = COUNT_BITS + 3;
  localparam int NYZW = 2 * COUNT_BITS;

  logic [COORD_BITS-1:0]      pos    [NUM_AXES];
  logic [COORD_BITS-1:0]      origin [NUM_AXES];
  logic [SIZE_BITS-1:0]       size   [NUM_AXES];
  logic [COUNTS_REG_BITS-1:0] counts;
  logic [COUNT_BITS-1:0]      n      [NUM_AXES];
  logic [DW-1:0]              span   [NUM_AXES];
  logic [NYZW-1:0]            nyz;

  assign pos[0] = pos_x;
  assign pos[1] = pos_y;
  assign pos[2] = pos_z;
  assign n[0]   = counts[COUNT_BITS-1:0];
  assign n[1]   = counts[2*COUNT_BITS-1:COUNT_BITS];
  assign n[2]   = counts[3*COUNT_BITS-1:2*COUNT_BITS];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        origin[a] <= '0;
        size[a]   <= SIZE_RESET;
      end
      counts <= COUNTS_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ORIGIN_X:    origin[0] <= COORD_BITS'(cfg_data);
        REG_ORIGIN_Y:    origin[1] <= COORD_BITS'(cfg_data);
        REG_ORIGIN_Z:    origin[2] <= COORD_BITS'(cfg_data);
        REG_CELL_SIZE_X: size[0]   <= cfg_data[SIZE_BITS-1:0];
        REG_CELL_SIZE_Y: size[1]   <= cfg_data[SIZE_BITS-1:0];
        REG_CELL_SIZE_Z: size[2]   <= cfg_data[SIZE_BITS-1:0];
        REG_CELL_COUNTS: counts    <= cfg_data[COUNTS_REG_BITS-1:0];
        default: ;
      endcase
    end
  end

  // derived grid terms, registered, so they follow the registers in the next cycle
  always_ff @(posedge clk) begin
    for (int a = 0; a < NUM_AXES; a++) begin
      span[a] <= DW'(n[a]) * DW'(size[a]);
    end
    nyz <= NYZW'(n[1]) * NYZW'(n[2]);
  end

  // stage enables: a stage moves when some stage at or after it has room
  logic [NS-1:0] v, en;

  always_comb begin
    for (int i = 0; i < NS; i++) begin
      en[i] = out_ready || !(&(v | ((NS'(1) << i) - NS'(1))));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= (v & ~en) | ({v[NS-2:0], in_valid} & en);
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v[NS-1];

  // stage A: offset from origin
  logic signed [OW-1:0] d [NUM_AXES];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        d[a] <= $signed({pos[a][COORD_BITS-1], pos[a]})
              - $signed({origin[a][COORD_BITS-1], origin[a]});
      end
    end
  end

  // stage B: box check
  logic [COORD_BITS-1:0] ud    [NUM_AXES];
  logic [NUM_AXES-1:0]   bad_b_next;
  logic [DW-1:0]         rem_b [NUM_AXES];
  logic [NUM_AXES-1:0]   bad_b;

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      ud[a]         = d[a][COORD_BITS-1:0];
      bad_b_next[a] = d[a][OW-1] || (n[a] == '0) || (size[a] == '0)
                   || (CMPW'(ud[a]) > CMPW'(span[a]));
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        rem_b[a] <= DW'(ud[a]);
      end
      bad_b <= bad_b_next;
    end
  end

  // divider stages
  logic [COUNT_BITS-1:0] quo [NUM_AXES];
  logic [NUM_AXES-1:0]   bad_d;

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
    pcl_axis_div #(.QB(COUNT_BITS)) u_div (
      .clk    (clk),
      .en     (en[COUNT_BITS+1:2]),
      .rem_in (rem_b[a]),
      .bad_in (bad_b[a]),
      .size   (size[a]),
      .quo    (quo[a]),
      .bad    (bad_d[a])
    );
  end

  // stage C: clamp far face, partial products
  logic [COUNT_BITS-1:0] cell_num [NUM_AXES];
  logic [IDX_BITS-1:0]   prod_x, prod_y;
  logic [COUNT_BITS-1:0] iz_c;
  logic                  bad_c;

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      cell_num[a] = (quo[a] >= n[a]) ? n[a] - COUNT_BITS'(1) : quo[a];
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_C]) begin
      prod_x <= IDX_BITS'(nyz) * IDX_BITS'(cell_num[0]);
      prod_y <= IDX_BITS'(n[2]) * IDX_BITS'(cell_num[1]);
      iz_c   <= cell_num[2];
      bad_c  <= |bad_d;
    end
  end

  // stage E: output register
  always_ff @(posedge clk) begin
    if (en[ST_E]) begin
      cell_index   <= bad_c ? '0 : prod_x + prod_y + IDX_BITS'(iz_c);
      out_of_range <= bad_c;
    end
  end

endmodule

>>> src/pcl_checker.sv
// Port-level checks for the particle cell locator, bound to the top level.
// Depends on pcl_pkg for the index width.
module pcl_checker import pcl_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [IDX_BITS-1:0] cell_index,
  input logic                out_of_range
);

  // out of range items carry index zero
  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_of_range |-> cell_index == '0)
    else $error("out_of_range item with nonzero cell_index");

  // input backpressure only when the output is stalled
  a_stall_src: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("in_ready low without an output stall");

  // reset empties the pipeline
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("out_valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(cell_index)
                                && $stable(out_of_range))
    else $error("stalled output item changed");

endmodule

bind particle_cell_locator_top pcl_checker u_pcl_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .cell_index   (cell_index),
  .out_of_range (out_of_range)
);

>>> tb/particle_cell_locator_top_tb.sv
`timescale 1ns / 100ps
// Random and directed test of particle_cell_locator_top: positions in, flat grid cell index out.
// Depends on pcl_pkg and the locator RTL; the class below predicts the cell for each position.

import pcl_pkg::*;

localparam int COORD_W = 32;
localparam int CNT_W   = 10;

typedef struct packed {
  logic [IDX_BITS-1:0] cell_idx;
  logic                oor;
} cell_result_t;

class cell_lookup;
  logic [COORD_W-1:0]         origin[NUM_AXES];
  logic [SIZE_BITS-1:0]       cell_len[NUM_AXES];
  logic [COUNTS_REG_BITS-1:0] counts;
  cell_result_t               owed_cells[$];
  int unsigned                mismatches;

  function new();
    origin     = '{default: '0};
    cell_len   = '{default: SIZE_RESET};
    counts     = COUNTS_RESET;
    mismatches = 0;
  endfunction

  function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    case (idx)
      REG_ORIGIN_X:    origin[0]   = data;
      REG_ORIGIN_Y:    origin[1]   = data;
      REG_ORIGIN_Z:    origin[2]   = data;
      REG_CELL_SIZE_X: cell_len[0] = data[SIZE_BITS-1:0];
      REG_CELL_SIZE_Y: cell_len[1] = data[SIZE_BITS-1:0];
      REG_CELL_SIZE_Z: cell_len[2] = data[SIZE_BITS-1:0];
      REG_CELL_COUNTS: counts      = data[COUNTS_REG_BITS-1:0];
      default: ;
    endcase
  endfunction

  function logic [CNT_W-1:0] axis_count(int a);
    return counts[a*CNT_W +: CNT_W];
  endfunction

  // Offset is formed in 64 bits, so pos - origin never wraps.
  function bit axis_cell(int a, logic [COORD_W-1:0] pos, output longint unsigned cnum);
    longint          d;
    longint unsigned ud, sz, n;
    cnum = 0;
    d  = longint'($signed(pos)) - longint'($signed(origin[a]));
    sz = 64'(cell_len[a]);
    n  = 64'(axis_count(a));
    if (d < 0 || n == 0 || sz == 0) return 0;
    ud = d;
    if (ud > n * sz) return 0;
    cnum = ud / sz;
    if (cnum >= n) cnum = n - 1;
    return 1;
  endfunction

  function void note_position(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                              logic [COORD_W-1:0] z);
    logic [COORD_W-1:0] p[NUM_AXES];
    longint unsigned    c[NUM_AXES];
    longint unsigned    flat;
    bit                 in_box;
    cell_result_t       r;
    p = '{x, y, z};
    in_box = 1'b1;
    for (int a = 0; a < NUM_AXES; a++) begin
      if (!axis_cell(a, p[a], c[a])) in_box = 1'b0;
    end
    flat = 64'(axis_count(1)) * 64'(axis_count(2)) * c[0] + 64'(axis_count(2)) * c[1] + c[2];
    r.cell_idx = in_box ? flat[IDX_BITS-1:0] : '0;
    r.oor      = !in_box;
    owed_cells.push_back(r);
  endfunction

  function void check_cell(logic [IDX_BITS-1:0] idx, logic oor);
    cell_result_t want;
    if (owed_cells.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected item: cell_index=%0d out_of_range=%b", idx, oor);
      return;
    end
    want = owed_cells.pop_front();
    if (idx !== want.cell_idx || oor !== want.oor) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: cell_index exp %0d got %0d, out_of_range exp %b got %b",
                 want.cell_idx, idx, want.oor, oor);
    end
  endfunction

  function int cells_owed();
    return owed_cells.size();
  endfunction
endclass

module particle_cell_locator_top_tb;
  localparam int IDLE_LIMIT = 4000;
  localparam int LONG_HOLD  = 300;
  localparam int MAX_GAP    = 18;
  localparam int LATENCY    = CNT_W + 4;
  localparam logic [CFG_IDX_BITS-1:0] REG_STRAY = 3'd7;

  logic                     clk, rst;
  logic                     in_valid, in_ready, out_valid, out_ready;
  logic [COORD_W-1:0]       pos_x, pos_y, pos_z;
  logic [IDX_BITS-1:0]      cell_index;
  logic                     out_of_range;
  logic                     cfg_valid, cfg_ready;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  cell_lookup grid = new();
  bit tx_steady, rx_steady, hold_output;

  particle_cell_locator_top #(.COUNT_BITS(CNT_W), .COORD_BITS(COORD_W)) dut (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int unsigned draw_gap(bit steady);
    return steady ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  task automatic send_position(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                               logic [COORD_W-1:0] z);
    int unsigned gap;
    gap = draw_gap(tx_steady);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    pos_x    <= x;
    pos_y    <= y;
    pos_z    <= z;
    do @(posedge clk); while (!in_ready);
    grid.note_position(x, y, z);
  endtask

  task automatic load_register(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    grid.write_reg(idx, data);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (grid.cells_owed() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic configure(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                           logic [31:0] sx, logic [31:0] sy, logic [31:0] sz,
                           logic [31:0] cnt, bit stray);
    settle();
    load_register(REG_ORIGIN_X, ox);
    load_register(REG_ORIGIN_Y, oy);
    load_register(REG_ORIGIN_Z, oz);
    load_register(REG_CELL_SIZE_X, sx);
    load_register(REG_CELL_SIZE_Y, sy);
    load_register(REG_CELL_SIZE_Z, sz);
    load_register(REG_CELL_COUNTS, cnt);
    if (stray) load_register(REG_STRAY, $urandom);
    cfg_valid <= 1'b0;
  endtask

  task automatic program_random_grid();
    logic [31:0]      org[NUM_AXES];
    logic [31:0]      len[NUM_AXES];
    logic [CNT_W-1:0] n[NUM_AXES];
    for (int a = 0; a < NUM_AXES; a++) begin
      org[a] = ($urandom_range(0, 2) == 0) ? $urandom
                                           : $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      case ($urandom_range(0, 15))
        0, 1:    len[a] = $urandom_range(1, 255);
        2:       len[a] = $urandom;
        3:       len[a] = 32'h7FFF_FFFF;
        4:       len[a] = 0;
        default: len[a] = $urandom_range(32'h4000, 32'h4_0000);
      endcase
      len[a][31] = $urandom_range(0, 1);
      case ($urandom_range(0, 15))
        0:             n[a] = CNT_W'(1);
        1:             n[a] = 10'd1023;
        2:             n[a] = CNT_W'(0);
        3, 4, 5, 6, 7: n[a] = CNT_W'($urandom_range(1, 16));
        default:       n[a] = CNT_W'($urandom_range(1, 1023));
      endcase
    end
    configure(org[0], org[1], org[2], len[0], len[1], len[2],
              {2'($urandom_range(0, 3)), n[2], n[1], n[0]}, $urandom_range(0, 3) == 0);
  endtask

  // Mostly near the box: faces, cell boundaries, just outside.
  function automatic logic [COORD_W-1:0] pick_coord(int a);
    longint unsigned sz, n, span, off;
    sz   = 64'(grid.cell_len[a]);
    n    = 64'(grid.axis_count(a));
    span = n * sz;
    case ($urandom_range(0, 11))
      0:       return $urandom;
      1:       off = span;
      2:       off = span + 1 + 64'($urandom_range(0, 3));
      3:       return grid.origin[a] - 32'(1 + $urandom_range(0, 3));
      4, 5:    off = sz * 64'($urandom_range(0, 32'(n))) - 1 + 64'($urandom_range(0, 2));
      default: off = {$urandom, $urandom} % (span + 1);
    endcase
    return grid.origin[a] + off[COORD_W-1:0];
  endfunction

  task automatic send_random_item();
    if ($urandom_range(0, 7) == 0) send_position($urandom, $urandom, $urandom);
    else send_position(pick_coord(0), pick_coord(1), pick_coord(2));
  endtask

  initial begin : stimulus
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    pos_x     <= '0;
    pos_y     <= '0;
    pos_z     <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_ORIGIN_X;
    cfg_data  <= '0;
    tx_steady   = 1'b0;
    rx_steady   = 1'b0;
    hold_output = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset grid: one unit cell at the origin
    send_position(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_position(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    send_position(32'h0000_8000, 32'h0000_FFFF, 32'h0001_0000);
    send_position(32'h0001_0001, 32'h0000_0000, 32'h0000_0000);
    send_position(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000);
    send_position(32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF);
    send_position(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);

    // lowest origin, widest cells, full counts; upper data bits must be dropped
    configure(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_position(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_position(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_position(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000);

    // highest origin, narrowest cells, plus a write to an unused index
    configure(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd1, 32'd1, 32'd1,
              {2'b00, 10'd1023, 10'd1023, 10'd1023}, 1'b1);
    send_position(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_position(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);

    // 4x5x6 grid at -2.0 with a different cell size per axis
    configure(32'hFFFE_0000, 32'hFFFE_0000, 32'hFFFE_0000,
              32'h0001_0000, 32'h0000_8000, 32'h0000_4000, {2'b00, 10'd6, 10'd5, 10'd4}, 1'b0);
    send_position(32'h0002_0000, 32'h0000_8000, 32'hFFFF_8000);
    send_position(32'hFFFE_0000, 32'hFFFE_0000, 32'hFFFE_0000);
    send_position(32'h0000_FFFF, 32'hFFFF_7FFF, 32'hFFFE_3FFF);
    send_position(32'h0002_0001, 32'h0000_0000, 32'hFFFE_0000);
    send_position(32'h0000_0000, 32'hFFFD_FFFF, 32'hFFFE_0000);

    // no cells along x
    configure(32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
              {2'b11, 10'd4, 10'd4, 10'd0}, 1'b0);
    send_position(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_position(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);

    // zero cell size along y
    configure(32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0001_0000,
              {2'b00, 10'd4, 10'd4, 10'd4}, 1'b0);
    send_position(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_position(32'h0001_8000, 32'h0000_0000, 32'h0002_0000);

    // back-pressure: output held off while input streams
    program_random_grid();
    tx_steady   = 1'b1;
    rx_steady   = 1'b0;
    hold_output = 1'b1;
    repeat (40) send_random_item();

    for (int phase = 0; phase < 10; phase++) begin
      program_random_grid();
      tx_steady = (phase % 4 == 1) || (phase % 4 == 2);
      rx_steady = (phase % 4 == 1) || (phase % 4 == 3);
      repeat (100) send_random_item();
    end

    settle();
    repeat (LATENCY) @(posedge clk);
    if (grid.mismatches == 0 && grid.cells_owed() == 0) begin
      $display("particle_cell_locator_top_tb: PASS");
    end else begin
      $display("particle_cell_locator_top_tb: FAIL");
    end
    $finish;
  end

  initial begin : result_sink
    int unsigned gap;
    out_ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_output) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_output = 1'b0;
      end
      gap = draw_gap(rx_steady);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      grid.check_cell(cell_index, out_of_range);
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    do @(posedge clk); while (rst);
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("particle_cell_locator_top_tb: FAIL");
    $finish;
  end

endmodule

>>> sim.f
src/pcl_pkg.sv
src/pcl_axis_div.sv
src/particle_cell_locator_top.sv
src/pcl_checker.sv
tb/particle_cell_locator_top_tb.sv
